// ----- rtl/pal_pkg.sv -----
// Shared types, codes and constants of the positional array list.
`timescale 1ns / 1ps

package pal_pkg;

  // Field widths of one request and one result.
  localparam int unsigned REQ_W = 3;
  localparam int unsigned POS_W = 11;
  localparam int unsigned POS2_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W = 2;
  localparam int unsigned CNT_OUT_W = 11;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned IN_W = 56;
  localparam int unsigned OUT_W = 48;
  localparam int unsigned OUT_PAD_W = OUT_W - (ST_W + VAL_W + CNT_OUT_W);

  localparam int unsigned DEPTH_DEFAULT = 1024;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SWAP = 3'd4;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    RS_POS  = 2'd0,
    RS_POS2 = 2'd1,
    RS_IDX  = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    WA_POS   = 2'd0,
    WA_POS2  = 2'd1,
    WA_SHIFT = 2'd2
  } wa_sel_e;

  typedef enum logic [1:0] {
    WD_VAL   = 2'd0,
    WD_RDATA = 2'd1,
    WD_HOLD  = 2'd2
  } wd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    dec_load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    hold_load;
    logic    we;
    wa_sel_e wa_sel;
    wd_sel_e wd_sel;
    logic    idx_load;
    logic    shift_step;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_ins;
    logic is_del;
    logic is_read;
    logic is_repl;
    logic is_swap;
    logic ok;
    logic at_end;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/positional_array_list.sv -----
// Top level of the positional array list: stream ports, controller and datapath.
`timescale 1ns / 1ps

// A dense ordered list of up to DEPTH signed 32-bit entries held in a single RAM,
// plus an element count that reset clears; entries are undefined until written.
// Each request transfer gives exactly one result transfer, one request at a time.
// A read fetches the entry at its position; a replace also writes the new value;
// a swap fetches both entries and writes each at the other position; a failed
// request goes straight to the result. An insert at p moves the entries from p
// on up by one unless it appends, then writes the value at p; a delete at p moves
// the entries after p down by one unless it removes the last entry, then shortens
// the list. The shift moves one entry per cycle through the single write port of
// the RAM. The next request is taken in the cycle after the result is registered;
// the result register lets the block accept it while the last result waits for the sink.
module positional_array_list #(
  parameter int unsigned DEPTH = pal_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // s_axis_tdata from bit 0: req_type[2:0], position[10:0],
  // second_position[9:0], value[31:0].
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [pal_pkg::IN_W-1:0]   s_axis_tdata,
  // m_axis_tdata from bit 0: status[1:0], data[31:0], count[10:0], zero fill.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [pal_pkg::OUT_W-1:0]  m_axis_tdata
);

  import pal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_tvalid_i(s_axis_tvalid),
    .in_tready_o(s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pal_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tdata_i  (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_tvalid_o(m_axis_tvalid),
    .out_tready_i(m_axis_tready),
    .out_tdata_o (m_axis_tdata)
  );

endmodule

// ----- rtl/pal_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module pal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pal_dp.sv -----
// Datapath of the positional array list: request registers, count, shift engine, RAM, output.
`timescale 1ns / 1ps

module pal_dp #(
  parameter int unsigned DEPTH = pal_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [pal_pkg::IN_W-1:0] in_tdata_i,
  input  pal_pkg::cmd_t            cmd_i,
  output pal_pkg::sts_t            sts_o,
  output logic                     out_tvalid_o,
  input  logic                     out_tready_i,
  output logic [pal_pkg::OUT_W-1:0] out_tdata_o
);

  import pal_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Request registers.
  logic [REQ_W-1:0]  kind_q;
  logic [POS_W-1:0]  pos_q;
  logic [POS2_W-1:0] pos2_q;
  logic [VAL_W-1:0]  val_q;

  logic [CW-1:0]     cnt_q;
  logic [AW-1:0]     idx_q;
  logic [AW-1:0]     wa_q;
  logic              pend_q;
  logic [VAL_W-1:0]  hold_q;
  logic [ST_W-1:0]   st_q;

  logic              out_valid_q;
  logic [ST_W-1:0]   out_status_q;
  logic [VAL_W-1:0]  out_data_q;
  logic [CNT_OUT_W-1:0] out_count_q;

  logic [CMPW-1:0]   pos_x;
  logic [CMPW-1:0]   pos2_x;
  logic [CMPW-1:0]   cnt_x;
  logic [CMPW-1:0]   cnt_m1;
  logic [CMPW-1:0]   pos_p1;
  logic [ST_W-1:0]   err_code;
  logic              is_ins;
  logic              is_del;
  logic              is_read;
  logic              is_repl;
  logic              is_swap;
  logic              out_free;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  assign pos_x = CMPW'(pos_q);
  assign pos2_x = CMPW'(pos2_q);
  assign cnt_x = CMPW'(cnt_q);
  assign cnt_m1 = cnt_x - CMPW'(1);
  assign pos_p1 = pos_x + CMPW'(1);

  assign is_ins = (kind_q == REQ_INSERT);
  assign is_del = (kind_q == REQ_DELETE);
  assign is_read = (kind_q == REQ_READ);
  assign is_repl = (kind_q == REQ_REPLACE);
  assign is_swap = (kind_q == REQ_SWAP);

  // The position check comes before the full check on insert.
  always_comb begin
    err_code = ST_RANGE;
    if (is_ins) begin
      if (pos_x > cnt_x) begin
        err_code = ST_RANGE;
      end else if (cnt_q == DEPTH_C) begin
        err_code = ST_FULL;
      end else begin
        err_code = ST_OK;
      end
    end else if (is_del || is_read || is_repl) begin
      err_code = (pos_x >= cnt_x) ? ST_RANGE : ST_OK;
    end else if (is_swap) begin
      err_code = (pos_x >= cnt_x || pos2_x >= cnt_x) ? ST_RANGE : ST_OK;
    end
  end

  assign out_free = !out_valid_q || out_tready_i;

  always_comb begin
    sts_o.is_ins = is_ins;
    sts_o.is_del = is_del;
    sts_o.is_read = is_read;
    sts_o.is_repl = is_repl;
    sts_o.is_swap = is_swap;
    sts_o.ok = (err_code == ST_OK);
    sts_o.at_end = is_ins ? (pos_x == cnt_x) : (pos_x == cnt_m1);
    sts_o.last = is_ins ? (idx_q == pos_x[AW-1:0]) : (CMPW'(idx_q) == cnt_m1);
    sts_o.out_free = out_free;
  end

  // RAM port selection.
  always_comb begin
    unique case (cmd_i.rd_sel)
      RS_POS:  ram_raddr = pos_x[AW-1:0];
      RS_POS2: ram_raddr = pos2_x[AW-1:0];
      RS_IDX:  ram_raddr = idx_q;
      default: ram_raddr = idx_q;
    endcase
    unique case (cmd_i.wa_sel)
      WA_POS:   ram_waddr = pos_x[AW-1:0];
      WA_POS2:  ram_waddr = pos2_x[AW-1:0];
      WA_SHIFT: ram_waddr = wa_q;
      default:  ram_waddr = wa_q;
    endcase
    unique case (cmd_i.wd_sel)
      WD_VAL:   ram_wdata = val_q;
      WD_RDATA: ram_wdata = ram_rdata;
      WD_HOLD:  ram_wdata = hold_q;
      default:  ram_wdata = ram_rdata;
    endcase
  end

  // The first shift step has no read data yet, so its write is dropped.
  assign ram_we = cmd_i.we && (!cmd_i.shift_step || pend_q);

  pal_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= in_tdata_i[REQ_W-1:0];
      pos_q <= in_tdata_i[REQ_W +: POS_W];
      pos2_q <= in_tdata_i[REQ_W + POS_W +: POS2_W];
      val_q <= in_tdata_i[REQ_W + POS_W + POS2_W +: VAL_W];
    end
    if (cmd_i.dec_load) begin
      st_q <= err_code;
    end
    if (cmd_i.hold_load) begin
      hold_q <= ram_rdata;
    end
    if (cmd_i.idx_load) begin
      idx_q <= is_ins ? cnt_m1[AW-1:0] : pos_p1[AW-1:0];
    end else if (cmd_i.shift_step) begin
      idx_q <= is_ins ? (idx_q - AW'(1)) : (idx_q + AW'(1));
      wa_q <= is_ins ? (idx_q + AW'(1)) : (idx_q - AW'(1));
    end
    if (cmd_i.out_load) begin
      out_status_q <= st_q;
      out_data_q <= (st_q == ST_OK && (is_read || is_repl)) ? hold_q : '0;
      out_count_q <= cnt_x[CNT_OUT_W-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.idx_load) begin
        pend_q <= 1'b0;
      end else if (cmd_i.shift_step) begin
        pend_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o = {{OUT_PAD_W{1'b0}}, out_count_q, out_data_q, out_status_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("element count above depth");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.cnt_inc && !cmd_i.cnt_dec |=> $stable(cnt_q))
    else $error("element count changed without a command");

  a_no_grow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> cnt_q != DEPTH_C)
    else $error("insert completed on a full list");

  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result loaded over a pending transfer");

endmodule

// ----- rtl/pal_ctrl.sv -----
// Controller state machine of the positional array list.
`timescale 1ns / 1ps

module pal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_tvalid_i,
  output logic          in_tready_o,
  input  pal_pkg::sts_t sts_i,
  output pal_pkg::cmd_t cmd_o
);

  import pal_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_DECODE  = 11'b000_0000_0010,
    S_RD_WAIT = 11'b000_0000_0100,
    S_REPL_WR = 11'b000_0000_1000,
    S_SW_RD2  = 11'b000_0001_0000,
    S_SW_WR1  = 11'b000_0010_0000,
    S_SW_WR2  = 11'b000_0100_0000,
    S_SHIFT   = 11'b000_1000_0000,
    S_DRAIN   = 11'b001_0000_0000,
    S_INS_PUT = 11'b010_0000_0000,
    S_FINISH  = 11'b100_0000_0000
  } state_e;

  state_e state_q;
  state_e state_d;

  assign in_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.dec_load = 1'b1;
        if (!sts_i.ok) begin
          state_d = S_FINISH;
        end else if (sts_i.is_read || sts_i.is_repl) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RS_POS;
          state_d = S_RD_WAIT;
        end else if (sts_i.is_swap) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RS_POS;
          state_d = S_SW_RD2;
        end else if (sts_i.is_ins) begin
          if (sts_i.at_end) begin
            state_d = S_INS_PUT;
          end else begin
            cmd_o.idx_load = 1'b1;
            state_d = S_SHIFT;
          end
        end else begin
          // Delete of the last entry only shortens the list.
          if (sts_i.at_end) begin
            cmd_o.cnt_dec = 1'b1;
            state_d = S_FINISH;
          end else begin
            cmd_o.idx_load = 1'b1;
            state_d = S_SHIFT;
          end
        end
      end
      S_RD_WAIT: begin
        cmd_o.hold_load = 1'b1;
        state_d = sts_i.is_repl ? S_REPL_WR : S_FINISH;
      end
      S_REPL_WR: begin
        cmd_o.we = 1'b1;
        cmd_o.wa_sel = WA_POS;
        cmd_o.wd_sel = WD_VAL;
        state_d = S_FINISH;
      end
      S_SW_RD2: begin
        cmd_o.hold_load = 1'b1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RS_POS2;
        state_d = S_SW_WR1;
      end
      S_SW_WR1: begin
        cmd_o.we = 1'b1;
        cmd_o.wa_sel = WA_POS;
        cmd_o.wd_sel = WD_RDATA;
        state_d = S_SW_WR2;
      end
      S_SW_WR2: begin
        cmd_o.we = 1'b1;
        cmd_o.wa_sel = WA_POS2;
        cmd_o.wd_sel = WD_HOLD;
        state_d = S_FINISH;
      end
      S_SHIFT: begin
        // Read one entry and write the one read in the previous cycle.
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RS_IDX;
        cmd_o.shift_step = 1'b1;
        cmd_o.we = 1'b1;
        cmd_o.wa_sel = WA_SHIFT;
        cmd_o.wd_sel = WD_RDATA;
        if (sts_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.we = 1'b1;
        cmd_o.wa_sel = WA_SHIFT;
        cmd_o.wd_sel = WD_RDATA;
        if (sts_i.is_ins) begin
          state_d = S_INS_PUT;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d = S_FINISH;
        end
      end
      S_INS_PUT: begin
        cmd_o.we = 1'b1;
        cmd_o.wa_sel = WA_POS;
        cmd_o.wd_sel = WD_VAL;
        cmd_o.cnt_inc = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
